[rtl/core/isa_pkg.sv]
package isa_pkg;

	localparam int CAPACITY_DEFAULT = 16;
	localparam int VALUE_W = 32;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_LOAD   = 7'b0000001,
		ST_SIFT   = 7'b0000010,
		ST_RD_L   = 7'b0000100,
		ST_RD_R   = 7'b0001000,
		ST_DECIDE = 7'b0010000,
		ST_SWAP   = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} seq_state_t;

	// Signed greater-than on raw words
	function automatic logic word_gt(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b);
		word_gt = $signed(a) > $signed(b);
	endfunction

endpackage

[rtl/core/integer_sorter_ascending.sv]
// Heap sorter for sets of signed 32-bit values.
// Input stream (s_axis_*): one value per request, tlast closes the set.
// Loading takes one request per cycle. Values beyond CAPACITY are dropped
// and every result of that set then carries the dropped flag.
// After the closing request the block builds a max-heap in its store and
// extracts it in place through one read and one write port. A sift level
// that swaps steps through read pos, read left, read right, decide and
// write pos, write child; the closing level of a sift ends at decide. Each
// extraction starts with an exchange of root and last entry. The n results
// then stream out ascending on m_axis_*; each is read from the store and
// then registered, and the next read waits until the output register is
// free or its result is taken by the receiver.
// tuser carries dropped, tlast marks the final result of the set.
// While sorting or emitting, s_axis_tready is low; a stalled receiver
// simply holds the current result until m_axis_tready rises.
// Reset (arst_n low) empties the set and drops any pending results; the
// store itself holds no reset value and only written entries are used.
module integer_sorter_ascending
	import isa_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] sorted_value
	output logic        m_axis_tlast,  // end_of_set
	output logic        m_axis_tuser   // [0] dropped
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = AW + 2;

	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [VALUE_W-1:0] rd_q;

	seq_state_t state_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] len_q;    // heap size
	logic [CW-1:0] build_q;  // build-phase roots left
	logic          xchg_q;   // root / last exchange in progress
	logic [PW-1:0] pos_q, big_q;
	logic [VALUE_W-1:0] pos_v_q, big_v_q;
	logic [CW-1:0] emit_q;   // results left

	logic [PW-1:0] lc, rc;
	assign lc = {pos_q[PW-2:0], 1'b1};
	assign rc = {pos_q[PW-2:0], 1'b0} + PW'(2);

	// Set size once the incoming request is counted
	logic [CW-1:0] fill_len;
	assign fill_len = (count_q < CW'(CAPACITY)) ? count_q + 1'b1 : count_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [VALUE_W-1:0] wr_data;
	logic rd_en;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	logic acc_in, acc_out;
	assign s_axis_tready = (state_q == ST_LOAD);
	assign acc_in = s_axis_tvalid && s_axis_tready;
	assign acc_out = m_axis_tvalid && m_axis_tready;

	// Right child wins when it lies inside the heap and beats the best so far, outside an exchange
	logic rc_win, need_swap;
	assign rc_win = !xchg_q && (PW'(len_q) > rc) && word_gt(rd_q, big_v_q);
	assign need_swap = xchg_q || rc_win || (big_q != pos_q);

	// DECIDE writes the winner into the pos slot, SWAP writes the old pos
	// value into the winner's slot
	always_comb begin
		wr_en = 1'b0; wr_addr = '0; wr_data = pos_v_q;
		rd_en = 1'b0; rd_addr = '0;
		unique case (state_q)
			ST_LOAD: begin
				wr_en = acc_in && (count_q < CW'(CAPACITY));
				wr_addr = count_q[AW-1:0];
				wr_data = s_axis_tdata;
			end
			ST_SIFT: begin
				rd_en = 1'b1; rd_addr = pos_q[AW-1:0];
			end
			ST_RD_L: begin
				rd_en = 1'b1;
				rd_addr = xchg_q ? big_q[AW-1:0] : lc[AW-1:0];
			end
			ST_RD_R: begin
				rd_en = !xchg_q; rd_addr = rc[AW-1:0];
			end
			ST_DECIDE: begin
				wr_en = need_swap;
				wr_addr = pos_q[AW-1:0];
				wr_data = rc_win ? rd_q : big_v_q;
			end
			ST_SWAP: begin
				wr_en = 1'b1;
				wr_addr = big_q[AW-1:0];
				wr_data = pos_v_q;
			end
			ST_EMIT: begin
				rd_en = 1'b1;
				rd_addr = AW'(len_q - emit_q);
			end
			default: ;
		endcase
	end

	// Output register
	logic [VALUE_W-1:0] out_data_q;
	logic out_valid_q, out_last_q, out_user_q, rd_pend_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			len_q <= '0;
			build_q <= '0;
			xchg_q <= 1'b0;
			pos_q <= '0;
			big_q <= '0;
			pos_v_q <= '0;
			big_v_q <= '0;
			emit_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			out_last_q <= 1'b0;
			out_user_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (acc_in) begin
						if (count_q < CW'(CAPACITY)) count_q <= count_q + 1'b1;
						else ovf_q <= 1'b1;
						if (s_axis_tlast) begin
							// start build: roots from len/2 down to 0
							len_q <= fill_len;
							build_q <= fill_len >> 1;
							pos_q <= PW'(fill_len >> 1);
							xchg_q <= 1'b0;
							state_q <= ST_SIFT;
						end
					end
				end
				ST_SIFT: state_q <= ST_RD_L;
				ST_RD_L: begin
					pos_v_q <= rd_q;
					if (!xchg_q) begin
						big_v_q <= rd_q; big_q <= pos_q;
					end
					state_q <= ST_RD_R;
				end
				ST_RD_R: begin
					if (xchg_q) begin
						big_v_q <= rd_q;
					end else if (PW'(len_q) > lc && word_gt(rd_q, big_v_q)) begin
						big_v_q <= rd_q; big_q <= lc;
					end
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (need_swap) begin
						if (rc_win) big_q <= rc;
						state_q <= ST_SWAP;
					end else begin
						// sift finished
						if (build_q != '0) begin
							build_q <= build_q - 1'b1;
							pos_q <= PW'(build_q - 1'b1);
							state_q <= ST_SIFT;
						end else if (len_q > CW'(1)) begin
							// exchange root and last entry, then sift the root
							xchg_q <= 1'b1;
							len_q <= len_q - 1'b1;
							pos_q <= '0;
							big_q <= PW'(len_q - 1'b1);
							state_q <= ST_SIFT;
						end else begin
							emit_q <= count_q;
							len_q <= count_q;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SWAP: begin
					// advance down the heap; an exchange restarts at the root
					if (!xchg_q) pos_q <= big_q;
					xchg_q <= 1'b0;
					state_q <= ST_SIFT;
				end
				ST_EMIT: ;
				default: state_q <= ST_LOAD;
			endcase
			if (state_q == ST_EMIT) begin
				if (acc_out) begin
					out_valid_q <= 1'b0;
					if (out_last_q) begin
						state_q <= ST_LOAD; count_q <= '0; ovf_q <= 1'b0;
						rd_pend_q <= 1'b0;
					end
				end
				if (rd_pend_q && (!out_valid_q || acc_out)) begin
					out_valid_q <= 1'b1;
					out_data_q <= rd_q;
					out_last_q <= (emit_q == '0);
					out_user_q <= ovf_q;
					rd_pend_q <= 1'b0;
				end else if (!rd_pend_q && emit_q != '0 && (!out_valid_q || acc_out)) begin
					rd_pend_q <= 1'b1;
					emit_q <= emit_q - 1'b1;
				end
			end
		end
	end

endmodule

[dv/integer_sorter_ascending_tb.sv]
`timescale 1ns / 100ps

module integer_sorter_ascending_tb;
	import isa_pkg::*;

	localparam int CAP = CAPACITY_DEFAULT;
	localparam int N_DIRECTED = 13;

	typedef struct packed {
		logic [31:0] value;
		logic        end_of_set;
		logic        dropped;
	} sorted_result_t;

	// one row of the directed table; has_exp marks a typed-in first result
	typedef struct {
		logic [31:0]    value;
		logic           last;
		logic           has_exp;
		sorted_result_t exp;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] value
	logic        s_axis_tlast;   // last
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] sorted_value
	logic        m_axis_tlast;   // end_of_set
	logic        m_axis_tuser;   // [0] dropped

	// predictor state: the open set as collected so far
	logic [31:0] set_store[CAP];
	int          set_count;
	logic        set_overflow;

	sorted_result_t sorted_q[$];
	sorted_result_t typed_q[$];
	int             error_count;
	bit             stim_done;
	directed_row_t  directed_tbl[N_DIRECTED];

	integer_sorter_ascending #(.CAPACITY(CAP)) i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Collect one request; on last, sort the open set and queue the results.
	task automatic collect_and_sort(input logic [31:0] v, input logic last);
		logic [31:0] buf_w[CAP];
		logic [31:0] tmp;
		int          i;
		int          j;
		if (set_count < CAP) begin
			set_store[set_count] = v;
			set_count++;
		end else begin
			set_overflow = 1'b1;
		end
		if (!last)
			return;
		for (i = 0; i < set_count; i++)
			buf_w[i] = set_store[i];
		// stable order equals heap order for plain values; insertion sort
		for (i = 1; i < set_count; i++) begin
			tmp = buf_w[i];
			j = i - 1;
			while (j >= 0 && $signed(buf_w[j]) > $signed(tmp)) begin
				buf_w[j + 1] = buf_w[j];
				j--;
			end
			buf_w[j + 1] = tmp;
		end
		for (i = 0; i < set_count; i++)
			sorted_q.push_back('{buf_w[i], i == set_count - 1, set_overflow});
		set_count = 0;
		set_overflow = 1'b0;
	endtask

	// Hold valid across back-to-back requests; drop it only for idle cycles
	// and after the closing request.
	task automatic send_request(input logic [31:0] v, input logic last);
		int idle;
		idle = $urandom_range(0, 6);
		if (idle != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		collect_and_sort(v, last);
		if (last) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Biased value: extremes, small range for duplicates, or full random.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: pick_value = 32'h8000_0000;
			1: pick_value = 32'h7fff_ffff;
			2: pick_value = $urandom_range(0, 6) - 3;
			default: pick_value = $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		while (sorted_q.size() != 0) @(posedge clk);
	endtask

	// Receiver: random stall per result, check against the oldest expectation.
	always @(posedge clk) begin
		sorted_result_t got;
		sorted_result_t exp;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
			if (sorted_q.size() == 0) begin
				$display("%0t: unexpected result %h last %b dropped %b", $time,
					got.value, got.end_of_set, got.dropped);
				error_count++;
			end else begin
				exp = sorted_q.pop_front();
				if (typed_q.size() != 0 && exp == typed_q[0]) begin
					if (got != typed_q[0]) begin
						$display("%0t: typed result expected %p actual %p", $time,
							typed_q[0], got);
						error_count++;
					end
					void'(typed_q.pop_front());
				end
				if (got.value !== exp.value) begin
					$display("%0t: sorted_value expected %h actual %h", $time,
						exp.value, got.value);
					error_count++;
				end
				if (got.end_of_set !== exp.end_of_set) begin
					$display("%0t: end_of_set expected %b actual %b", $time,
						exp.end_of_set, got.end_of_set);
					error_count++;
				end
				if (got.dropped !== exp.dropped) begin
					$display("%0t: dropped expected %b actual %b", $time,
						exp.dropped, got.dropped);
					error_count++;
				end
			end
		end
	end

	// Stall pattern: draw a wait count per result, some stretches without stalls.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		int k;
		int n;
		int sets_done;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		arst_n        = 1'b0;
		error_count   = 0;
		stim_done     = 0;
		set_count     = 0;
		set_overflow  = 1'b0;

		// single-element sets: extremes and zero come back unchanged
		directed_tbl[0] = '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}};
		directed_tbl[1] = '{32'h7fff_ffff, 1'b1, 1'b1, '{32'h7fff_ffff, 1'b1, 1'b0}};
		directed_tbl[2] = '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}};
		// mixed set with duplicates and both extremes
		directed_tbl[3] = '{32'h7fff_ffff, 1'b0, 1'b0, '{default: '0}};
		directed_tbl[4] = '{32'hffff_ffff, 1'b0, 1'b0, '{default: '0}};
		directed_tbl[5] = '{32'h8000_0000, 1'b0, 1'b0, '{default: '0}};
		directed_tbl[6] = '{32'hffff_ffff, 1'b0, 1'b0, '{default: '0}};
		directed_tbl[7] = '{32'h0000_0001, 1'b1, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}};
		// two equal values
		directed_tbl[8] = '{32'h5555_aaaa, 1'b0, 1'b0, '{default: '0}};
		directed_tbl[9] = '{32'h5555_aaaa, 1'b1, 1'b0, '{default: '0}};
		directed_tbl[10] = '{32'haaaa_5555, 1'b0, 1'b0, '{default: '0}};
		directed_tbl[11] = '{32'h0f0f_f0f0, 1'b0, 1'b0, '{default: '0}};
		directed_tbl[12] = '{32'hf0f0_0f0f, 1'b1, 1'b0, '{default: '0}};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIRECTED; k++) begin
			if (directed_tbl[k].has_exp)
				typed_q.push_back(directed_tbl[k].exp);
			send_request(directed_tbl[k].value, directed_tbl[k].last);
		end

		// Full store, then the closing item overflows too: all flagged dropped.
		for (k = 0; k < CAP; k++)
			send_request(32'(CAP - k), 1'b0);
		typed_q.push_back('{32'h0000_0001, 1'b0, 1'b1});
		send_request(32'h7fff_ffff, 1'b1);

		// hold off until the block has drained every result
		wait_drained();

		// Random sets, mostly well inside capacity, a few overfull.
		sets_done = 0;
		k = 0;
		while (k < 80 || sets_done < 12) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(CAP, CAP + 3)
				: $urandom_range(1, 8);
			for (int e = 0; e < n; e++) begin
				send_request(pick_value(), e == n - 1);
				k++;
			end
			sets_done++;
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0 && typed_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/isa_pkg.sv
rtl/core/integer_sorter_ascending.sv
dv/integer_sorter_ascending_tb.sv
